// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/cfta_pkg.sv
`default_nettype none
package cfta_pkg;
   localparam int COMP_BITS = 16;
   localparam int MAG_BITS = COMP_BITS + 1;
   localparam int SIDE_BITS = 13;
   localparam int TEX_BITS = 12;
   localparam int OFF_BITS = 26;
   localparam int MAX_SIDE = 4096;
   // quotient bits: floor(s*(size-1)/(2d)) < MAX_SIDE
   localparam int QBITS = $clog2(MAX_SIDE);
   // numerator is s*(size-1), s <= 2d
   localparam int PROD_BITS = MAG_BITS + 1 + SIDE_BITS;
   localparam int DEN_BITS = MAG_BITS + 1;
   localparam int NCELLS = QBITS;

   localparam logic [1:0] CSR_WIDTH = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_CHAN = 2'd2;

   localparam logic [2:0] FACE_RIGHT = 3'd0;
   localparam logic [2:0] FACE_LEFT = 3'd1;
   localparam logic [2:0] FACE_TOP = 3'd2;
   localparam logic [2:0] FACE_BOTTOM = 3'd3;
   localparam logic [2:0] FACE_FRONT = 3'd4;
   localparam logic [2:0] FACE_BACK = 3'd5;

   // per-item data handed from cell to cell
   typedef struct packed {
      logic                 valid;
      logic [2:0]           face;
      logic                 invalid;
      logic [DEN_BITS-1:0]  den;
      logic [PROD_BITS-1:0] rem_x;
      logic [PROD_BITS-1:0] rem_y;
      logic [QBITS-1:0]     q_x;
      logic [QBITS-1:0]     q_y;
      logic [SIDE_BITS-1:0] width;
      logic [2:0]           chan;
   } cell_data_type;
endpackage
`default_nettype wire

// File: hw/rtl/cfta_front.sv
`default_nettype none
// Face selection, clamp and numerator product; two register stages
module cfta_front import cfta_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 go,
   input  wire logic [COMP_BITS-1:0] dir_x,
   input  wire logic [COMP_BITS-1:0] dir_y,
   input  wire logic [COMP_BITS-1:0] dir_z,
   input  wire logic [SIDE_BITS-1:0] width,
   input  wire logic [SIDE_BITS-1:0] height,
   input  wire logic [2:0]           chan,
   output cell_data_type             data_out
);
   typedef struct packed {
      logic                 valid;
      logic [2:0]           face;
      logic                 invalid;
      logic [DEN_BITS-1:0]  den;
      logic [DEN_BITS-1:0]  s_x;
      logic [DEN_BITS-1:0]  s_y;
      logic                 zx;
      logic                 zy;
      logic [SIDE_BITS-1:0] w;
      logic [SIDE_BITS-1:0] h;
      logic [2:0]           ch;
   } sel_type;

   sel_type sel_ff, sel_in;
   cell_data_type out_ff, out_in;

   logic signed [MAG_BITS-1:0] x, y, z, ax, ay, az, un, vn, d, sx, sy;
   logic [SIDE_BITS-1:0] w_sat, h_sat;

   // clamp a sum to [0, 2d]
   function automatic logic [DEN_BITS-1:0] clamp_s(input logic signed [MAG_BITS-1:0] n,
                                                   input logic signed [MAG_BITS-1:0] dd);
      logic signed [DEN_BITS-1:0] s;
      logic signed [DEN_BITS-1:0] top;
      s = DEN_BITS'(n) + DEN_BITS'(dd);
      top = DEN_BITS'(dd) <<< 1;
      if (s < 0) clamp_s = '0;
      else if (s > top) clamp_s = top;
      else clamp_s = s;
   endfunction

   // pick face and numerators
   always_comb begin
      x = MAG_BITS'($signed(dir_x));
      y = MAG_BITS'($signed(dir_y));
      z = MAG_BITS'($signed(dir_z));
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      az = z < 0 ? -z : z;
      sel_in = '0;
      if (ax > ay && ax > az) begin
         d = ax;
         sel_in.face = x > 0 ? FACE_RIGHT : FACE_LEFT;
         un = x > 0 ? -z : z;
         vn = -y;
      end else if (ay > ax && ay > az) begin
         d = ay;
         sel_in.face = y > 0 ? FACE_TOP : FACE_BOTTOM;
         un = x;
         vn = y > 0 ? z : -z;
      end else begin
         d = az;
         sel_in.face = z > 0 ? FACE_FRONT : FACE_BACK;
         un = z > 0 ? x : -x;
         vn = -y;
      end
      w_sat = width == '0 ? SIDE_BITS'(1) :
              (width > SIDE_BITS'(MAX_SIDE) ? SIDE_BITS'(MAX_SIDE) : width);
      h_sat = height == '0 ? SIDE_BITS'(1) :
              (height > SIDE_BITS'(MAX_SIDE) ? SIDE_BITS'(MAX_SIDE) : height);
      sx = un;
      sy = vn;
      sel_in.valid = go;
      sel_in.invalid = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
      sel_in.den = DEN_BITS'(d) << 1;
      sel_in.s_x = clamp_s(sx, d);
      sel_in.s_y = clamp_s(sy, d);
      sel_in.zx = sx > 0;
      sel_in.zy = sy > 0;
      sel_in.w = w_sat;
      sel_in.h = h_sat;
      sel_in.ch = chan == 3'd0 ? 3'd1 : (chan > 3'd4 ? 3'd4 : chan);
      if (sel_in.den == '0) begin
         // zero divisor: saturate the sum to numerator sign
         sel_in.s_x = sel_in.zx ? DEN_BITS'(2) : '0;
         sel_in.s_y = sel_in.zy ? DEN_BITS'(2) : '0;
         sel_in.den = DEN_BITS'(2);
      end
   end

   // form the products for the divide chain
   always_comb begin
      out_in = '0;
      out_in.valid = sel_ff.valid;
      out_in.face = sel_ff.invalid ? FACE_RIGHT : sel_ff.face;
      out_in.invalid = sel_ff.invalid;
      out_in.den = sel_ff.den;
      out_in.rem_x = sel_ff.invalid ? '0 :
                     PROD_BITS'(sel_ff.s_x) * PROD_BITS'(sel_ff.w - SIDE_BITS'(1));
      out_in.rem_y = sel_ff.invalid ? '0 :
                     PROD_BITS'(sel_ff.s_y) * PROD_BITS'(sel_ff.h - SIDE_BITS'(1));
      out_in.width = sel_ff.w;
      out_in.chan = sel_ff.ch;
   end

   // advance both stages; reset empties them
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= '0;
         out_ff <= '0;
      end else begin
         sel_ff <= sel_in;
         out_ff <= out_in;
      end
   end

   assign data_out = out_ff;
endmodule
`default_nettype wire

// File: hw/rtl/cfta_div_cell.sv
`default_nettype none
// One restoring divide step for both coordinates, registered
module cfta_div_cell import cfta_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [3:0]    bit_pos,
   input  cell_data_type      data_in,
   output cell_data_type      data_out
);
   cell_data_type data_ff, data_in_c;
   logic [PROD_BITS+QBITS-1:0] trial;

   // try subtracting the shifted divisor from each remainder
   always_comb begin
      data_in_c = data_in;
      trial = (PROD_BITS+QBITS)'(data_in.den) << bit_pos;
      if ((PROD_BITS+QBITS)'(data_in.rem_x) >= trial) begin
         data_in_c.rem_x = data_in.rem_x - PROD_BITS'(trial);
         data_in_c.q_x = data_in.q_x | (QBITS'(1) << bit_pos);
      end
      if ((PROD_BITS+QBITS)'(data_in.rem_y) >= trial) begin
         data_in_c.rem_y = data_in.rem_y - PROD_BITS'(trial);
         data_in_c.q_y = data_in.q_y | (QBITS'(1) << bit_pos);
      end
   end

   // advance the item; reset empties the cell
   always_ff @(posedge clock) begin
      if (reset) data_ff <= '0;
      else data_ff <= data_in_c;
   end

   assign data_out = data_ff;
endmodule
`default_nettype wire

// File: hw/rtl/cubemap_face_texel_address_unit.sv
`default_nettype none
// Channel   Ports                               Handshake
// request   req_dir_x/y/z                       start & !busy
// response  rsp_face/texel_x/texel_y/...        rsp_valid, one cycle
// config    csr_index, csr_data                 csr_valid & csr_ready
//
// An item passes two front stages, one divide cell per quotient bit, then
// offset multiply and result register. One item enters per cycle; busy
// is always low. Reset is synchronous and clears the valid chain and the
// configuration registers to their defaults. Results cannot be stalled.
module cubemap_face_texel_address_unit import cfta_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [COMP_BITS-1:0] req_dir_x,
   input  wire logic [COMP_BITS-1:0] req_dir_y,
   input  wire logic [COMP_BITS-1:0] req_dir_z,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_face,
   output logic [TEX_BITS-1:0]       rsp_texel_x,
   output logic [TEX_BITS-1:0]       rsp_texel_y,
   output logic [OFF_BITS-1:0]       rsp_byte_offset,
   output logic                      rsp_invalid,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [1:0]           csr_index,
   input  wire logic [31:0]          csr_data
);
`include "assert_macros.svh"

   logic [SIDE_BITS-1:0] width_ff, height_ff;
   logic [2:0] chan_ff;

   // write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= SIDE_BITS'(256);
         height_ff <= SIDE_BITS'(256);
         chan_ff <= 3'd3;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WIDTH: width_ff <= csr_data[SIDE_BITS-1:0];
            CSR_HEIGHT: height_ff <= csr_data[SIDE_BITS-1:0];
            CSR_CHAN: chan_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy = 1'b0;

   cell_data_type chain [NCELLS+1];

   cfta_front u_front (
      .clock(clock), .reset(reset), .go(start && !busy),
      .dir_x(req_dir_x), .dir_y(req_dir_y), .dir_z(req_dir_z),
      .width(width_ff), .height(height_ff), .chan(chan_ff),
      .data_out(chain[0])
   );

   // divide chain, most significant quotient bit first
   for (genvar i = 0; i < NCELLS; i++) begin : g_cell
      cfta_div_cell u_cell (
         .clock(clock), .reset(reset), .bit_pos(4'(NCELLS - 1 - i)),
         .data_in(chain[i]), .data_out(chain[i+1])
      );
   end

   cell_data_type last;
   assign last = chain[NCELLS];

   // row product, then add column and scale by channels
   logic                  s1_valid_ff, out_valid_ff;
   logic [2:0]            s1_face_ff, s1_chan_ff, out_face_ff;
   logic                  s1_inv_ff, out_inv_ff;
   logic [QBITS-1:0]      s1_qx_ff, s1_qy_ff, out_tx_ff, out_ty_ff;
   logic [OFF_BITS-1:0]   s1_row_ff, out_off_ff;
   logic [OFF_BITS+2:0]   off_full;

   assign off_full = (OFF_BITS+3)'(s1_row_ff + OFF_BITS'(s1_qx_ff)) * (OFF_BITS+3)'(s1_chan_ff);

   always_ff @(posedge clock) begin
      s1_face_ff <= last.face;
      s1_inv_ff <= last.invalid;
      s1_qx_ff <= last.q_x;
      s1_qy_ff <= last.q_y;
      s1_chan_ff <= last.chan;
      s1_row_ff <= OFF_BITS'(last.q_y) * OFF_BITS'(last.width);
      out_face_ff <= s1_face_ff;
      out_inv_ff <= s1_inv_ff;
      out_tx_ff <= s1_qx_ff;
      out_ty_ff <= s1_qy_ff;
      out_off_ff <= off_full[OFF_BITS-1:0];
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= last.valid;
         out_valid_ff <= s1_valid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_face = out_face_ff;
   assign rsp_texel_x = TEX_BITS'(out_tx_ff);
   assign rsp_texel_y = TEX_BITS'(out_ty_ff);
   assign rsp_byte_offset = out_off_ff;
   assign rsp_invalid = out_inv_ff;

   `ASSERT_IMPL(a_inv_zero, clock, reset, rsp_valid && rsp_invalid,
      rsp_face == FACE_RIGHT && rsp_texel_x == '0 && rsp_byte_offset == '0)
   `ASSERT_IMPL(a_face_range, clock, reset, rsp_valid, rsp_face <= FACE_BACK)
   `ASSERT_NEXT(a_chain_tail, clock, reset, s1_valid_ff, rsp_valid)
endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import cfta_pkg::*;

   localparam int LATENCY     = 16;
   localparam int STALL_LIMIT = 5000;
   localparam int RAND_PER_SETTING = 220;

   typedef struct packed {
      logic [2:0]          face;
      logic [TEX_BITS-1:0] texel_x;
      logic [TEX_BITS-1:0] texel_y;
      logic [OFF_BITS-1:0] byte_offset;
      logic                invalid;
   } texel_addr_type;

   typedef struct {
      logic [COMP_BITS-1:0] x;
      logic [COMP_BITS-1:0] y;
      logic [COMP_BITS-1:0] z;
      bit                   known;
      texel_addr_type       addr;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [COMP_BITS-1:0] req_dir_x = '0;
   logic [COMP_BITS-1:0] req_dir_y = '0;
   logic [COMP_BITS-1:0] req_dir_z = '0;
   logic rsp_valid;
   logic [2:0] rsp_face;
   logic [TEX_BITS-1:0] rsp_texel_x;
   logic [TEX_BITS-1:0] rsp_texel_y;
   logic [OFF_BITS-1:0] rsp_byte_offset;
   logic rsp_invalid;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_WIDTH;
   logic [31:0] csr_data = '0;

   // shadow copy of the size and channel registers
   logic [SIDE_BITS-1:0] face_w_reg = 13'd256;
   logic [SIDE_BITS-1:0] face_h_reg = 13'd256;
   logic [2:0]           chan_reg   = 3'd3;

   texel_addr_type pending_addr[$];
   dir_row_type    dir_rows[$];
   int mismatches = 0;
   int items_sent = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   int settings_run = 0;

   always #5 clock = ~clock;

   cubemap_face_texel_address_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .rsp_valid(rsp_valid), .rsp_face(rsp_face), .rsp_texel_x(rsp_texel_x),
      .rsp_texel_y(rsp_texel_y), .rsp_byte_offset(rsp_byte_offset),
      .rsp_invalid(rsp_invalid), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // floor((clamp(n/d,-1,1)+1)/2 * (size-1)), d >= 0
   function automatic longint texel_coord(longint n, longint d, longint size);
      longint s;
      if (d == 0) begin
         return (n > 0) ? size - 1 : 0;
      end
      s = n + d;
      if (s < 0) s = 0;
      if (s > 2 * d) s = 2 * d;
      return (s * (size - 1)) / (2 * d);
   endfunction

   function automatic texel_addr_type texel_address(logic [COMP_BITS-1:0] rx,
                                                    logic [COMP_BITS-1:0] ry,
                                                    logic [COMP_BITS-1:0] rz);
      texel_addr_type a;
      longint x, y, z, ax, ay, az, un, vn, d, w, h, ch, tx, ty, off;
      logic [2:0] f;
      x = longint'($signed(rx));
      y = longint'($signed(ry));
      z = longint'($signed(rz));
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      az = z < 0 ? -z : z;
      a = '{face: FACE_RIGHT, texel_x: '0, texel_y: '0, byte_offset: '0, invalid: 1'b0};
      if (x == 0 && y == 0 && z == 0) begin
         a.invalid = 1'b1;
         return a;
      end
      // pick the major axis: x, then y, ties fall to z
      if (ax > ay && ax > az) begin
         d = ax;
         if (x > 0) begin f = FACE_RIGHT; un = -z; vn = -y; end
         else begin f = FACE_LEFT; un = z; vn = -y; end
      end else if (ay > ax && ay > az) begin
         d = ay;
         if (y > 0) begin f = FACE_TOP; un = x; vn = z; end
         else begin f = FACE_BOTTOM; un = x; vn = -z; end
      end else begin
         d = az;
         if (z > 0) begin f = FACE_FRONT; un = x; vn = -y; end
         else begin f = FACE_BACK; un = -x; vn = -y; end
      end
      w = face_w_reg < 1 ? 1 : (face_w_reg > MAX_SIDE ? MAX_SIDE : face_w_reg);
      h = face_h_reg < 1 ? 1 : (face_h_reg > MAX_SIDE ? MAX_SIDE : face_h_reg);
      ch = chan_reg < 1 ? 1 : (chan_reg > 4 ? 4 : chan_reg);
      tx = texel_coord(un, d, w);
      ty = texel_coord(vn, d, h);
      off = (ty * w + tx) * ch;
      a.face = f;
      a.texel_x = tx[TEX_BITS-1:0];
      a.texel_y = ty[TEX_BITS-1:0];
      a.byte_offset = off[OFF_BITS-1:0];
      return a;
   endfunction

   // record the expected address of each accepted item, check each result
   always @(posedge clock) begin
      texel_addr_type got, want;
      if (!reset) begin
         if (start && !busy) begin
            pending_addr.push_back(texel_address(req_dir_x, req_dir_y, req_dir_z));
         end
         if (rsp_valid) begin
            results_seen++;
            got = '{face: rsp_face, texel_x: rsp_texel_x, texel_y: rsp_texel_y,
                    byte_offset: rsp_byte_offset, invalid: rsp_invalid};
            if (pending_addr.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result: face=%0d", rsp_face);
            end else begin
               want = pending_addr.pop_front();
               if (got != want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display(
                        "mismatch: exp f=%0d x=%0d y=%0d off=%0d inv=%0b, got %0d %0d %0d %0d %0b",
                        want.face, want.texel_x, want.texel_y, want.byte_offset,
                        want.invalid, got.face, got.texel_x, got.texel_y,
                        got.byte_offset, got.invalid);
               end
            end
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[cubemap_face_texel_address_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_WIDTH:  face_w_reg = value[SIDE_BITS-1:0];
         CSR_HEIGHT: face_h_reg = value[SIDE_BITS-1:0];
         CSR_CHAN:   chan_reg   = value[2:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      repeat ($urandom_range(0, 2)) @(posedge clock);
   endtask

   // wait for every result, then let the pipeline drain
   task automatic drain();
      while (pending_addr.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_dir(logic [COMP_BITS-1:0] x, logic [COMP_BITS-1:0] y,
                           logic [COMP_BITS-1:0] z);
      int g;
      start     <= 1'b1;
      req_dir_x <= x;
      req_dir_y <= y;
      req_dir_z <= z;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      g = gap_length();
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   function automatic logic [COMP_BITS-1:0] comp(int lo, int hi);
      int v;
      v = $urandom_range(0, hi - lo) + lo;
      return v[COMP_BITS-1:0];
   endfunction

   task automatic random_dirs(int count);
      logic [COMP_BITS-1:0] a, b, c;
      int kind, m;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 9);
         a = COMP_BITS'($urandom); b = COMP_BITS'($urandom); c = COMP_BITS'($urandom);
         case (kind)
            // small components make ties and zero vectors likely
            0, 1: begin a = comp(-3, 3); b = comp(-3, 3); c = comp(-3, 3); end
            // equal magnitudes on two or three axes
            2: begin
               m = $urandom_range(0, 32767);
               a = $urandom_range(0, 1) ? COMP_BITS'(m) : COMP_BITS'(-m);
               b = $urandom_range(0, 1) ? COMP_BITS'(m) : COMP_BITS'(-m);
               c = $urandom_range(0, 1) ? 16'd0 :
                   ($urandom_range(0, 1) ? COMP_BITS'(m) : COMP_BITS'(-m));
            end
            // minor components at or near the major magnitude, any order
            3: begin
               m = $urandom_range(1, 32767);
               a = $urandom_range(0, 1) ? COMP_BITS'(m) : COMP_BITS'(-m);
               b = comp(-m, m);
               c = comp(-m, m);
               if (kind == 3 && $urandom_range(0, 2) == 0) {a, b, c} = {c, a, b};
               else if ($urandom_range(0, 1)) {a, b, c} = {b, c, a};
            end
            // full-scale extremes
            4: begin
               a = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
               b = comp(-32768, 32767);
               c = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            end
            default: ;
         endcase
         send_dir(a, b, c);
         // hold off now and then until the pipeline is empty
         if ($urandom_range(0, 199) == 0) begin
            start <= 1'b0;
            while (pending_addr.size() != 0) @(posedge clock);
         end
      end
   endtask

   task automatic add_row(int x, int y, int z, bit known, texel_addr_type a);
      dir_row_type r;
      r.x = x[COMP_BITS-1:0];
      r.y = y[COMP_BITS-1:0];
      r.z = z[COMP_BITS-1:0];
      r.known = known;
      r.addr = a;
      dir_rows.push_back(r);
   endtask

   initial begin
      texel_addr_type none, zero_addr, plus_x, got;
      none = '{face: '0, texel_x: '0, texel_y: '0, byte_offset: '0, invalid: 1'b0};
      zero_addr = none;
      zero_addr.invalid = 1'b1;
      plus_x = '{face: FACE_RIGHT, texel_x: 12'd127, texel_y: 12'd127,
                 byte_offset: 26'd97917, invalid: 1'b0};

      // directed rows at reset settings
      add_row(0, 0, 0, 1, zero_addr);
      add_row(32767, 0, 0, 1, plus_x);
      add_row(-32768, 0, 0, 0, none);
      add_row(0, 32767, 0, 0, none);
      add_row(0, -32768, 0, 0, none);
      add_row(0, 0, 32767, 0, none);
      add_row(0, 0, -32768, 0, none);
      add_row(100, 100, 0, 0, none);
      add_row(-100, 100, 0, 0, none);
      add_row(-100, -100, 0, 0, none);
      add_row(7, 7, 7, 0, none);
      add_row(-7, -7, -7, 0, none);
      add_row(5, -5, 3, 0, none);
      add_row(1000, 1000, -1000, 0, none);
      add_row(32767, -32768, 32767, 0, none);
      add_row(-32768, 32767, -32768, 0, none);
      add_row(10, 20, -30, 0, none);
      add_row(-30, 10, 20, 0, none);
      add_row(20, -30, 10, 0, none);
      add_row(32767, 32767, -32767, 0, none);
      add_row(1, 0, 0, 0, none);
      add_row(0, 0, -1, 0, none);
      add_row(0, 0, 0, 1, zero_addr);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].known) begin
            got = texel_address(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
            if (got != dir_rows[i].addr) begin
               mismatches++;
               $display("table row %0d disagrees with the address calculation", i);
            end
         end
         send_dir(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
      end
      random_dirs(RAND_PER_SETTING);
      settings_run++;

      // smallest faces, one byte per texel; an out-of-list index is ignored
      start <= 1'b0;
      drain();
      write_reg(CSR_WIDTH, 32'd1);
      write_reg(CSR_HEIGHT, 32'd1);
      write_reg(CSR_CHAN, 32'd1);
      write_reg(2'd3, 32'hFFFF_FFFF);
      random_dirs(RAND_PER_SETTING);
      settings_run++;

      // largest faces
      start <= 1'b0;
      drain();
      write_reg(CSR_WIDTH, 32'd4096);
      write_reg(CSR_HEIGHT, 32'd4096);
      write_reg(CSR_CHAN, 32'd4);
      random_dirs(RAND_PER_SETTING);
      settings_run++;

      // out-of-range values that saturate, upper data bits masked
      start <= 1'b0;
      drain();
      write_reg(CSR_WIDTH, 32'hFFFF_FFFF);
      write_reg(CSR_HEIGHT, 32'd0);
      write_reg(CSR_CHAN, 32'd0);
      random_dirs(RAND_PER_SETTING / 2);
      start <= 1'b0;
      drain();
      write_reg(CSR_WIDTH, 32'h0000_2000);
      write_reg(CSR_HEIGHT, 32'd5000);
      write_reg(CSR_CHAN, 32'd7);
      random_dirs(RAND_PER_SETTING / 2);
      settings_run++;

      // odd random sizes
      start <= 1'b0;
      drain();
      write_reg(CSR_WIDTH, $urandom_range(2, 300));
      write_reg(CSR_HEIGHT, $urandom_range(2, 4096));
      write_reg(CSR_CHAN, $urandom_range(1, 4));
      random_dirs(RAND_PER_SETTING);
      settings_run++;

      start <= 1'b0;
      drain();
      $display("covered %0d directions over %0d register settings, %0d results checked",
               items_sent, settings_run, results_seen);
      $display("settings included unit faces, 4096 faces and saturating values");
      if (mismatches == 0 && pending_addr.size() == 0) begin
         $display("[cubemap_face_texel_address_unit] OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[cubemap_face_texel_address_unit] ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
